/* sv/raster_line_irq_timer_macros.svh */
// Assertion macros used by the raster line IRQ timer checker.
`ifndef RASTER_LINE_IRQ_TIMER_MACROS_SVH
`define RASTER_LINE_IRQ_TIMER_MACROS_SVH

// Check a property on every clock edge outside reset.
`define RLIT_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition is followed by a consequence in the next cycle.
`define RLIT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* sv/rlit_pkg.sv */
// Package with types and constants of the raster line IRQ timer.
package rlit_pkg;

	localparam int LINE_W     = 9;
	localparam int VIS_W      = 8;
	localparam int DOT_W      = 9;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 9;

	localparam logic [LINE_W-1:0] LAST_LINE       = 9'd261;
	localparam logic [LINE_W-1:0] NMI_DELAY_LINES = 9'd8;
	localparam logic [VIS_W-1:0]  VIS_LINES_RST   = 8'd224;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_VIS_LINES_NEXT = 3'd0,
		CFG_VERT_IRQ_EN    = 3'd1,
		CFG_HORIZ_IRQ_EN   = 3'd2,
		CFG_VERT_IRQ_LINE  = 3'd3,
		CFG_HORIZ_IRQ_DOT  = 3'd4,
		CFG_NMI_EN         = 3'd5,
		CFG_AUTO_POLL_EN   = 3'd6
	} rlit_cfg_idx_t;

	typedef struct packed {
		logic [LINE_W-1:0] target_line;
		logic [DOT_W-1:0]  beam_dot;
		logic              irq_masked;
	} rlit_in_t;

	typedef struct packed {
		logic              nmi_raised;
		logic              irq_raised;
		logic              frame_end;
		logic              joypad_poll;
		logic              field_parity;
		logic [LINE_W-1:0] line_now;
	} rlit_out_t;

	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_RUN  = 1'b1
	} rlit_state_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic accept;
		logic advance;
		logic finish;
	} rlit_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic need_adv;
		logic out_busy;
	} rlit_status_t;

endpackage

/* sv/rlit_ctrl.sv */
// Controller state machine of the raster line IRQ timer.
module rlit_ctrl import rlit_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	input  rlit_status_t status,
	output logic         in_stall,
	output rlit_cmd_t    cmd
);

	rlit_state_t state_q;
	rlit_state_t state_nxt;
	logic        ready;
	logic        finish;

	// Hold the state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Decide the next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_nxt = ST_RUN;
				end
			end
			ST_RUN: begin
				if (!status.need_adv && !status.out_busy) begin
					state_nxt = in_valid ? ST_RUN : ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// Drive the commands
	always_comb begin
		ready  = 1'b0;
		finish = 1'b0;
		cmd    = '0;
		case (state_q)
			ST_IDLE: begin
				ready = 1'b1;
			end
			ST_RUN: begin
				finish      = !status.need_adv && !status.out_busy;
				ready       = finish;
				cmd.advance = status.need_adv;
			end
			default: ready = 1'b0;
		endcase
		cmd.finish = finish;
		cmd.accept = ready && in_valid;
		in_stall   = !ready;
	end

endmodule

/* sv/rlit_dp.sv */
// Datapath of the raster line IRQ timer: line counter, events and IRQ match.
module rlit_dp import rlit_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  rlit_in_t              in_data,
	input  rlit_cmd_t             cmd,
	input  logic                  out_stall,
	output rlit_status_t          status,
	output logic                  out_valid,
	output rlit_out_t             out_data
);

	// Configuration registers
	logic [VIS_W-1:0]  vis_next_q;
	logic              vert_en_q;
	logic              horiz_en_q;
	logic [LINE_W-1:0] vert_line_q;
	logic [DOT_W-1:0]  horiz_dot_q;
	logic              nmi_en_q;
	logic              poll_en_q;

	// Timer state
	logic [LINE_W-1:0] line_q;
	logic [VIS_W-1:0]  vis_q;
	logic              vdone_q;
	logic              hdone_q;
	logic              armed_q;
	logic              field_q;

	// Current item
	logic [LINE_W-1:0] target_q;
	logic [DOT_W-1:0]  dot_q;
	logic              masked_q;
	logic              wrap_q;
	logic              ev_nmi_q;
	logic              ev_frame_q;
	logic              ev_poll_q;

	logic              out_valid_q;
	rlit_out_t         out_q;

	logic [LINE_W-1:0] target_clamp;
	logic [LINE_W-1:0] line_nxt;
	logic              at_zero;
	logic [VIS_W-1:0]  vis_eff;
	logic [LINE_W-1:0] vis_ext;
	logic              armed_eff;
	logic              hit_frame;
	logic              hit_poll;
	logic              hit_nmi;
	logic              vmatch;
	logic              hmatch;
	logic              irq_v;
	logic              irq_h;
	logic              irq;

	// Clamp the target to the last line
	assign target_clamp = (in_data.target_line > LAST_LINE) ? LAST_LINE : in_data.target_line;

	// Per-line events of one advance
	assign at_zero   = (line_q >= LAST_LINE);
	assign line_nxt  = at_zero ? '0 : line_q + LINE_W'(1);
	assign vis_eff   = at_zero ? vis_next_q : vis_q;
	assign vis_ext   = {1'b0, vis_eff};
	assign armed_eff = at_zero || armed_q;
	assign hit_frame = (line_nxt == vis_ext);
	assign hit_poll  = (line_nxt == vis_ext + LINE_W'(1)) && poll_en_q;
	assign hit_nmi   = (line_nxt == vis_ext + NMI_DELAY_LINES) && armed_eff;

	// IRQ match after catch-up
	assign vmatch = (target_q == vert_line_q) && !vdone_q;
	assign hmatch = (dot_q >= horiz_dot_q) && !hdone_q;
	always_comb begin
		irq_v = 1'b0;
		irq_h = 1'b0;
		if (!masked_q) begin
			if (vert_en_q && horiz_en_q) begin
				irq_v = vmatch && hmatch;
				irq_h = vmatch && hmatch;
			end else if (vert_en_q) begin
				irq_v = vmatch;
			end else if (horiz_en_q) begin
				irq_h = hmatch;
			end
		end
		irq = irq_v || irq_h;
	end

	assign status.need_adv = wrap_q || (target_q > line_q);
	assign status.out_busy = out_valid_q && out_stall;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vis_next_q  <= VIS_LINES_RST;
			vert_en_q   <= 1'b0;
			horiz_en_q  <= 1'b0;
			vert_line_q <= '0;
			horiz_dot_q <= '0;
			nmi_en_q    <= 1'b0;
			poll_en_q   <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_VIS_LINES_NEXT: vis_next_q  <= cfg_data[VIS_W-1:0];
				CFG_VERT_IRQ_EN:    vert_en_q   <= cfg_data[0];
				CFG_HORIZ_IRQ_EN:   horiz_en_q  <= cfg_data[0];
				CFG_VERT_IRQ_LINE:  vert_line_q <= cfg_data[LINE_W-1:0];
				CFG_HORIZ_IRQ_DOT:  horiz_dot_q <= cfg_data[DOT_W-1:0];
				CFG_NMI_EN:         nmi_en_q    <= cfg_data[0];
				CFG_AUTO_POLL_EN:   poll_en_q   <= cfg_data[0];
				default:            vis_next_q  <= vis_next_q;
			endcase
		end
	end

	// Advance the line counter and run the per-line events
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_q     <= LAST_LINE;
			vis_q      <= VIS_LINES_RST;
			vdone_q    <= 1'b0;
			hdone_q    <= 1'b0;
			armed_q    <= 1'b0;
			field_q    <= 1'b0;
			wrap_q     <= 1'b0;
			ev_nmi_q   <= 1'b0;
			ev_frame_q <= 1'b0;
			ev_poll_q  <= 1'b0;
		end else begin
			if (cmd.advance) begin
				line_q  <= line_nxt;
				vis_q   <= vis_eff;
				hdone_q <= 1'b0;
				armed_q <= armed_eff && !hit_nmi;
				if (at_zero) begin
					vdone_q <= 1'b0;
					wrap_q  <= 1'b0;
				end
				if (hit_frame) begin
					field_q    <= !field_q;
					ev_frame_q <= 1'b1;
				end
				if (hit_poll) begin
					ev_poll_q <= 1'b1;
				end
				if (hit_nmi && nmi_en_q) begin
					ev_nmi_q <= 1'b1;
				end
			end
			if (cmd.finish) begin
				if (irq_v) begin
					vdone_q <= 1'b1;
				end
				if (irq_h) begin
					hdone_q <= 1'b1;
				end
			end
			// Start a new beat; finish never moves the line counter
			if (cmd.accept) begin
				wrap_q     <= (line_q > target_clamp);
				ev_nmi_q   <= 1'b0;
				ev_frame_q <= 1'b0;
				ev_poll_q  <= 1'b0;
			end
		end
	end

	// Capture the item
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			target_q <= target_clamp;
			dot_q    <= in_data.beam_dot;
			masked_q <= in_data.irq_masked;
		end
	end

	// Output register: load on finish, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			out_q.nmi_raised   <= ev_nmi_q;
			out_q.irq_raised   <= irq;
			out_q.frame_end    <= ev_frame_q;
			out_q.joypad_poll  <= ev_poll_q;
			out_q.field_parity <= field_q;
			out_q.line_now     <= line_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

/* sv/raster_line_irq_timer.sv */
// Top level of the raster line IRQ timer.
//
// The input channel (in_valid, in_stall, in_data) carries one beat per beam
// sample: target line, dot position and the CPU interrupt mask. The output
// channel (out_valid, out_stall, out_data) returns one result beat per input
// beat, in order: NMI, IRQ, frame end, joypad poll, field bit and line.
// Configuration registers are written through cfg_we, cfg_index, cfg_data
// while the block is idle; writes take effect on the next clock edge.
//
// An item is accepted, then the counter advances line by line up to its
// target; the line counter steps one line per cycle. The item finishes once
// no advance is left and the output register is free; the result is loaded
// there on finish, and the next item can be accepted in that same cycle. A
// catch-up may run across the frame wrap.
// Reset sets the counter to the last line, the visible count and its next value
// to 224 and clears the other flags and configuration. When the receiver stalls, the result
// waits in the output register; one further item can be taken and worked
// on meanwhile, and it then waits for the output to free up.
module raster_line_irq_timer import rlit_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  rlit_in_t              in_data,
	output logic                  out_valid,
	input  logic                  out_stall,
	output rlit_out_t             out_data
);

	rlit_cmd_t    cmd;
	rlit_status_t status;

	rlit_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.status   (status),
		.in_stall (in_stall),
		.cmd      (cmd)
	);

	rlit_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_data   (in_data),
		.cmd       (cmd),
		.out_stall (out_stall),
		.status    (status),
		.out_valid (out_valid),
		.out_data  (out_data)
	);

endmodule

/* sv/rlit_chk.sv */
// Port checker of the raster line IRQ timer and its bind.
`include "raster_line_irq_timer_macros.svh"

module rlit_chk import rlit_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  cfg_we,
	input logic                  in_valid,
	input logic                  in_stall,
	input rlit_in_t              in_data,
	input logic                  out_valid,
	input logic                  out_stall,
	input rlit_out_t             out_data
);

	logic [1:0] pend_q;
	logic       in_beat;
	logic       out_beat;

	assign in_beat  = in_valid && !in_stall;
	assign out_beat = out_valid && !out_stall;

	// Count beats taken in and not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (in_beat && !out_beat) begin
			pend_q <= pend_q + 2'd1;
		end else if (out_beat && !in_beat) begin
			pend_q <= pend_q - 2'd1;
		end
	end

	`RLIT_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(out_data), "result beat changed while stalled")
	`RLIT_ASSERT(a_no_invented, clk, arst_n, !out_valid || (pend_q != 2'd0), "result beat without a pending item")
	`RLIT_ASSERT(a_pend_bound, clk, arst_n, (pend_q != 2'd3) && !(pend_q == 2'd2 && in_beat && !out_beat), "more than two items in flight")
	`RLIT_ASSERT(a_line_range, clk, arst_n, !out_valid || (out_data.line_now <= LAST_LINE), "line beyond the last line")
	`RLIT_ASSERT(a_cfg_idle, clk, arst_n, !cfg_we || (pend_q == 2'd0), "register write while items are in flight")

endmodule

bind raster_line_irq_timer rlit_chk u_rlit_chk (.*);

/* verif/tb_top.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the raster line IRQ timer: directed table, then random beats.
module tb_top;
	import rlit_pkg::*;

	localparam int CLK_HALF       = 5;
	localparam int RESET_CYCLES   = 5;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int TAIL_CYCLES    = 300;
	localparam int PHASES         = 8;
	localparam int PHASE_BEATS    = 150;
	localparam int DIR_ROWS       = 41;

	typedef enum logic {
		ROW_BEAT = 1'b0,
		ROW_CFG  = 1'b1
	} row_kind_t;

	// One directed step: a register write or a beat, optionally with a fixed expectation
	typedef struct {
		row_kind_t             kind;
		rlit_cfg_idx_t         idx;
		logic [CFG_DATA_W-1:0] val;
		rlit_in_t              beat;
		bit                    fixed;
		rlit_out_t             want;
	} dir_row_t;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;
	logic                  in_valid  = 1'b0;
	logic                  in_stall;
	rlit_in_t              in_data   = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	rlit_out_t             out_data;

	// Register mirror
	logic [VIS_W-1:0]  r_vis_next;
	bit                r_vert_en;
	bit                r_horiz_en;
	logic [LINE_W-1:0] r_vert_line;
	logic [DOT_W-1:0]  r_horiz_dot;
	bit                r_nmi_en;
	bit                r_poll_en;

	// Raster state mirror
	logic [LINE_W-1:0] line_cnt;
	logic [VIS_W-1:0]  vis_lines;
	bit                v_done;
	bit                h_done;
	bit                nmi_armed;
	bit                field;
	bit                ev_nmi;
	bit                ev_frame;
	bit                ev_poll;

	rlit_out_t pending_results [$];
	int        mismatches = 0;
	int        gap_pct    = 0;
	int        stall_pct  = 0;

	// Expected flags are packed as {nmi, irq, frame_end, poll, field} then the line
	dir_row_t dir_rows [DIR_ROWS] = '{
		'{ROW_BEAT, CFG_VIS_LINES_NEXT, 9'd0, {9'd0, 9'd0, 1'b0}, 1'b1, {5'b00000, 9'd0}},
		'{ROW_BEAT, CFG_VIS_LINES_NEXT, 9'd0, {9'd261, 9'd511, 1'b1}, 1'b1, {5'b00101, 9'd261}},
		'{ROW_BEAT, CFG_VIS_LINES_NEXT, 9'd0, {9'd511, 9'd0, 1'b0}, 1'b1, {5'b00001, 9'd261}},
		'{ROW_CFG, CFG_NMI_EN, 9'd1, '0, 1'b0, '0},
		'{ROW_CFG, CFG_AUTO_POLL_EN, 9'd1, '0, 1'b0, '0},
		'{ROW_CFG, CFG_VIS_LINES_NEXT, 9'd239, '0, 1'b0, '0},
		'{ROW_BEAT, CFG_VIS_LINES_NEXT, 9'd0, {9'd0, 9'd0, 1'b0}, 1'b1, {5'b00001, 9'd0}},
		'{ROW_BEAT, CFG_VIS_LINES_NEXT, 9'd0, {9'd261, 9'd0, 1'b0}, 1'b1, {5'b10110, 9'd261}},
		// zero visible lines: frame start and frame end on the same line
		'{ROW_CFG, CFG_VIS_LINES_NEXT, 9'd0, '0, 1'b0, '0},
		'{ROW_BEAT, CFG_VIS_LINES_NEXT, 9'd0, {9'd5, 9'd0, 1'b0}, 1'b0, '0},
		'{ROW_BEAT, CFG_VIS_LINES_NEXT, 9'd0, {9'd20, 9'd0, 1'b0}, 1'b0, '0},
		// NMI line past the last line never fires
		'{ROW_CFG, CFG_VIS_LINES_NEXT, 9'd255, '0, 1'b0, '0},
		'{ROW_BEAT, CFG_VIS_LINES_NEXT, 9'd0, {9'd261, 9'd0, 1'b0}, 1'b0, '0},
		'{ROW_BEAT, CFG_VIS_LINES_NEXT, 9'd0, {9'd0, 9'd0, 1'b0}, 1'b0, '0},
		'{ROW_BEAT, CFG_VIS_LINES_NEXT, 9'd0, {9'd261, 9'd0, 1'b0}, 1'b0, '0},
		'{ROW_BEAT, CFG_VIS_LINES_NEXT, 9'd0, {9'd3, 9'd0, 1'b0}, 1'b0, '0},
		// vertical-only IRQ, masked then once per frame
		'{ROW_CFG, CFG_VIS_LINES_NEXT, 9'd224, '0, 1'b0, '0},
		'{ROW_CFG, CFG_VERT_IRQ_EN, 9'd1, '0, 1'b0, '0},
		'{ROW_CFG, CFG_VERT_IRQ_LINE, 9'd100, '0, 1'b0, '0},
		'{ROW_BEAT, CFG_VIS_LINES_NEXT, 9'd0, {9'd100, 9'd0, 1'b1}, 1'b0, '0},
		'{ROW_BEAT, CFG_VIS_LINES_NEXT, 9'd0, {9'd100, 9'd0, 1'b0}, 1'b0, '0},
		'{ROW_BEAT, CFG_VIS_LINES_NEXT, 9'd0, {9'd100, 9'd0, 1'b0}, 1'b0, '0},
		// horizontal-only IRQ around the dot threshold, once per line
		'{ROW_CFG, CFG_VERT_IRQ_EN, 9'd0, '0, 1'b0, '0},
		'{ROW_CFG, CFG_HORIZ_IRQ_EN, 9'd1, '0, 1'b0, '0},
		'{ROW_CFG, CFG_HORIZ_IRQ_DOT, 9'd300, '0, 1'b0, '0},
		'{ROW_BEAT, CFG_VIS_LINES_NEXT, 9'd0, {9'd101, 9'd299, 1'b0}, 1'b0, '0},
		'{ROW_BEAT, CFG_VIS_LINES_NEXT, 9'd0, {9'd101, 9'd300, 1'b0}, 1'b0, '0},
		'{ROW_BEAT, CFG_VIS_LINES_NEXT, 9'd0, {9'd101, 9'd511, 1'b0}, 1'b0, '0},
		'{ROW_BEAT, CFG_VIS_LINES_NEXT, 9'd0, {9'd102, 9'd511, 1'b0}, 1'b0, '0},
		// combined H/V match with a target beyond the last line
		'{ROW_CFG, CFG_VERT_IRQ_EN, 9'd1, '0, 1'b0, '0},
		'{ROW_CFG, CFG_VERT_IRQ_LINE, 9'd261, '0, 1'b0, '0},
		'{ROW_CFG, CFG_HORIZ_IRQ_DOT, 9'd0, '0, 1'b0, '0},
		'{ROW_BEAT, CFG_VIS_LINES_NEXT, 9'd0, {9'd511, 9'd0, 1'b0}, 1'b0, '0},
		'{ROW_CFG, CFG_VERT_IRQ_LINE, 9'd511, '0, 1'b0, '0},
		'{ROW_CFG, CFG_HORIZ_IRQ_DOT, 9'd511, '0, 1'b0, '0},
		'{ROW_BEAT, CFG_VIS_LINES_NEXT, 9'd0, {9'd300, 9'd511, 1'b0}, 1'b0, '0},
		// NMI disabled: still disarmed at its line, so no late NMI after enabling
		'{ROW_CFG, CFG_NMI_EN, 9'd0, '0, 1'b0, '0},
		'{ROW_BEAT, CFG_VIS_LINES_NEXT, 9'd0, {9'd0, 9'd0, 1'b0}, 1'b0, '0},
		'{ROW_BEAT, CFG_VIS_LINES_NEXT, 9'd0, {9'd250, 9'd0, 1'b0}, 1'b0, '0},
		'{ROW_CFG, CFG_NMI_EN, 9'd1, '0, 1'b0, '0},
		'{ROW_BEAT, CFG_VIS_LINES_NEXT, 9'd0, {9'd251, 9'd0, 1'b0}, 1'b0, '0}
	};

	raster_line_irq_timer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	always #CLK_HALF clk = ~clk;

	// Load reset values into the mirror
	function automatic void reset_raster_model();
		r_vis_next  = VIS_LINES_RST;
		r_vert_en   = 1'b0;
		r_horiz_en  = 1'b0;
		r_vert_line = '0;
		r_horiz_dot = '0;
		r_nmi_en    = 1'b0;
		r_poll_en   = 1'b0;
		line_cnt    = LAST_LINE;
		vis_lines   = VIS_LINES_RST;
		v_done      = 1'b0;
		h_done      = 1'b0;
		nmi_armed   = 1'b0;
		field       = 1'b0;
	endfunction

	function automatic void mirror_cfg(rlit_cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
		case (idx)
			CFG_VIS_LINES_NEXT: r_vis_next  = val[VIS_W-1:0];
			CFG_VERT_IRQ_EN:    r_vert_en   = val[0];
			CFG_HORIZ_IRQ_EN:   r_horiz_en  = val[0];
			CFG_VERT_IRQ_LINE:  r_vert_line = val[LINE_W-1:0];
			CFG_HORIZ_IRQ_DOT:  r_horiz_dot = val[DOT_W-1:0];
			CFG_NMI_EN:         r_nmi_en    = val[0];
			CFG_AUTO_POLL_EN:   r_poll_en   = val[0];
			default: ;
		endcase
	endfunction

	// Step one line and run the per-line events in order
	function automatic void advance_raster_line();
		h_done   = 1'b0;
		line_cnt = (line_cnt >= LAST_LINE) ? '0 : line_cnt + 1'b1;
		if (line_cnt == 0) begin
			v_done    = 1'b0;
			vis_lines = r_vis_next;
			nmi_armed = 1'b1;
		end
		if (int'(line_cnt) == int'(vis_lines)) begin
			field    = ~field;
			ev_frame = 1'b1;
		end
		if (int'(line_cnt) == int'(vis_lines) + 1 && r_poll_en)
			ev_poll = 1'b1;
		if (int'(line_cnt) == int'(vis_lines) + int'(NMI_DELAY_LINES) && nmi_armed) begin
			nmi_armed = 1'b0;
			if (r_nmi_en)
				ev_nmi = 1'b1;
		end
	endfunction

	// Catch up to the target line, then evaluate the H/V IRQ
	function automatic rlit_out_t predict_result(rlit_in_t beat);
		logic [LINE_W-1:0] tgt;
		bit                irq;
		bit                v_hit;
		bit                h_hit;
		rlit_out_t         res;
		tgt      = (beat.target_line > LAST_LINE) ? LAST_LINE : beat.target_line;
		ev_nmi   = 1'b0;
		ev_frame = 1'b0;
		ev_poll  = 1'b0;
		irq      = 1'b0;
		if (line_cnt > tgt) begin
			while (line_cnt != 0)
				advance_raster_line();
		end
		while (tgt > line_cnt)
			advance_raster_line();
		if (!beat.irq_masked) begin
			v_hit = (tgt == r_vert_line) && !v_done;
			h_hit = (beat.beam_dot >= r_horiz_dot) && !h_done;
			if (r_vert_en && r_horiz_en) begin
				if (v_hit && h_hit) begin
					v_done = 1'b1;
					h_done = 1'b1;
					irq    = 1'b1;
				end
			end else if (r_vert_en) begin
				if (v_hit) begin
					v_done = 1'b1;
					irq    = 1'b1;
				end
			end else if (r_horiz_en) begin
				if (h_hit) begin
					h_done = 1'b1;
					irq    = 1'b1;
				end
			end
		end
		res.nmi_raised   = ev_nmi;
		res.irq_raised   = irq;
		res.frame_end    = ev_frame;
		res.joypad_poll  = ev_poll;
		res.field_parity = field;
		res.line_now     = line_cnt;
		return res;
	endfunction

	// Mostly one line ahead, with repeats, short jumps, wraps and out-of-range targets
	function automatic rlit_in_t random_beat();
		rlit_in_t beat;
		int       pick;
		int       tgt;
		pick = $urandom_range(99);
		if (pick < 55)
			tgt = (line_cnt >= LAST_LINE) ? 0 : int'(line_cnt) + 1;
		else if (pick < 65)
			tgt = int'(line_cnt);
		else if (pick < 80) begin
			tgt = int'(line_cnt) + $urandom_range(2, 40);
			if (tgt > int'(LAST_LINE))
				tgt = $urandom_range(0, 20);
		end else if (pick < 95)
			tgt = $urandom_range(0, int'(LAST_LINE));
		else
			tgt = $urandom_range(int'(LAST_LINE) + 1, 511);
		beat.target_line = tgt[LINE_W-1:0];
		pick = $urandom_range(9);
		beat.beam_dot   = (pick == 0) ? '0 : (pick == 1) ? '1 : DOT_W'($urandom_range(0, 511));
		beat.irq_masked = ($urandom_range(3) == 0);
		return beat;
	endfunction

	task automatic write_reg(input rlit_cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		mirror_cfg(idx, val);
	endtask

	// Drop valid and wait until every expected beat has come back
	task automatic drain_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
	endtask

	// Offer one beat, hold it until accepted, then queue its expectation
	task automatic drive_beat(input rlit_in_t beat, input bit fixed, input rlit_out_t want);
		rlit_out_t predicted;
		@(negedge clk);
		while ($urandom_range(99) < gap_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= beat;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		predicted = predict_result(beat);
		pending_results.push_back(fixed ? want : predicted);
	endtask

	task automatic randomize_cfg();
		int                    pick;
		logic [CFG_DATA_W-1:0] val;
		pick = $urandom_range(5);
		case (pick)
			0:       val = 9'd224;
			1:       val = 9'd239;
			2:       val = 9'd0;
			3:       val = 9'd255;
			default: val = CFG_DATA_W'($urandom_range(224, 239));
		endcase
		write_reg(CFG_VIS_LINES_NEXT, val);
		write_reg(CFG_VERT_IRQ_EN, CFG_DATA_W'($urandom_range(1)));
		write_reg(CFG_HORIZ_IRQ_EN, CFG_DATA_W'($urandom_range(1)));
		pick = $urandom_range(19);
		if (pick < 2)
			val = '0;
		else if (pick < 4)
			val = '1;
		else if (pick < 7)
			val = CFG_DATA_W'($urandom_range(int'(LAST_LINE) + 1, 510));
		else
			val = CFG_DATA_W'($urandom_range(0, int'(LAST_LINE)));
		write_reg(CFG_VERT_IRQ_LINE, val);
		pick = $urandom_range(9);
		val  = (pick == 0) ? '0 : (pick == 1) ? '1 : CFG_DATA_W'($urandom_range(0, 511));
		write_reg(CFG_HORIZ_IRQ_DOT, val);
		write_reg(CFG_NMI_EN, CFG_DATA_W'($urandom_range(1)));
		write_reg(CFG_AUTO_POLL_EN, CFG_DATA_W'($urandom_range(1)));
	endtask

	// Random receiver stall
	always @(negedge clk)
		out_stall <= ($urandom_range(99) < stall_pct);

	// Compare each result beat with the oldest expectation
	always @(posedge clk) begin
		rlit_out_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				$error("unexpected result beat: line_now %0d", out_data.line_now);
				mismatches++;
			end else begin
				want = pending_results.pop_front();
				if (out_data.nmi_raised !== want.nmi_raised) begin
					$error("nmi_raised: expected %0d, actual %0d",
						want.nmi_raised, out_data.nmi_raised);
					mismatches++;
				end
				if (out_data.irq_raised !== want.irq_raised) begin
					$error("irq_raised: expected %0d, actual %0d",
						want.irq_raised, out_data.irq_raised);
					mismatches++;
				end
				if (out_data.frame_end !== want.frame_end) begin
					$error("frame_end: expected %0d, actual %0d",
						want.frame_end, out_data.frame_end);
					mismatches++;
				end
				if (out_data.joypad_poll !== want.joypad_poll) begin
					$error("joypad_poll: expected %0d, actual %0d",
						want.joypad_poll, out_data.joypad_poll);
					mismatches++;
				end
				if (out_data.field_parity !== want.field_parity) begin
					$error("field_parity: expected %0d, actual %0d",
						want.field_parity, out_data.field_parity);
					mismatches++;
				end
				if (out_data.line_now !== want.line_now) begin
					$error("line_now: expected %0d, actual %0d",
						want.line_now, out_data.line_now);
					mismatches++;
				end
			end
		end
	end

	// Abort when no beat moves on either channel for too long
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
				quiet = 0;
			else
				quiet++;
		end
		$display("*** FAILED ***");
		$finish;
	end

	initial begin
		reset_raster_model();
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Walk the directed table
		foreach (dir_rows[i]) begin
			if (dir_rows[i].kind == ROW_CFG) begin
				drain_results();
				write_reg(dir_rows[i].idx, dir_rows[i].val);
			end else begin
				drive_beat(dir_rows[i].beat, dir_rows[i].fixed, dir_rows[i].want);
			end
		end

		// Random phases, each with fresh registers and its own idling pattern
		for (int ph = 0; ph < PHASES; ph++) begin
			drain_results();
			case (ph % 4)
				0: begin gap_pct = 0;  stall_pct = 0;  end
				1: begin gap_pct = 68; stall_pct = 0;  end
				2: begin gap_pct = 0;  stall_pct = 68; end
				default: begin gap_pct = 22; stall_pct = 22; end
			endcase
			randomize_cfg();
			repeat (PHASE_BEATS)
				drive_beat(random_beat(), 1'b0, '0);
		end

		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

/* sim.f */
+incdir+sv
sv/rlit_pkg.sv
sv/rlit_ctrl.sv
sv/rlit_dp.sv
sv/raster_line_irq_timer.sv
sv/rlit_chk.sv
verif/tb_top.sv
